// File: rtl/hte_pkg.sv
// hte_pkg: types, register map, reset values and limits of the hover thrust estimator
// used by hover_thrust_rls_estimator; depends on nothing
package hte_pkg;

  localparam int unsigned GainW = 24;
  localparam int unsigned CovW  = 32;
  localparam int unsigned DivW  = 50;  // divisor and partial remainder
  localparam int unsigned QuoW  = 42;  // quotient bits of the longest division
  localparam int unsigned MulW  = 64;  // shift-add accumulator
  localparam int unsigned MprW  = 21;  // serial multiplier operand
  localparam int unsigned CntW  = 6;

  localparam logic [GainW-1:0] GAIN_MAX   = 24'hFFFFFF;
  localparam logic [GainW-1:0] GAIN_RESET = 24'd1285760;
  localparam logic [47:0]      GAIN_MIN   = 48'd66;
  localparam logic [CovW-1:0]  P_ONE      = 32'd4096;
  localparam logic [CovW-1:0]  P_LIMIT    = 32'd4096000000;

  localparam logic [15:0] LAMBDA_RESET = 16'd32113;
  localparam logic [14:0] GRAV_RESET   = 15'd10045;
  localparam logic [15:0] IHT_RESET    = 16'd16384;
  localparam logic [15:0] TMIN_RESET   = 16'd6554;
  localparam logic [15:0] TMAX_RESET   = 16'd26214;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_LAMBDA = 3'd0;
  localparam logic [2:0] REG_GRAV   = 3'd1;
  localparam logic [2:0] REG_IHT    = 3'd2;
  localparam logic [2:0] REG_TMIN   = 3'd3;
  localparam logic [2:0] REG_TMAX   = 3'd4;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic               command;
    logic        [15:0] throttle_cmd;
    logic signed [15:0] vertical_accel;
  } in_t;

  typedef struct packed {
    logic [15:0]      hover_throttle;
    logic [GainW-1:0] gain_estimate;
    logic             sample_used;
    logic             guard_reset;
  } out_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_TP   = 11'b000_0000_0010,
    S_TPT  = 11'b000_0000_0100,
    S_PRED = 11'b000_0000_1000,
    S_KDIV = 11'b000_0001_0000,
    S_KRES = 11'b000_0010_0000,
    S_PDIV = 11'b000_0100_0000,
    S_HSET = 11'b000_1000_0000,
    S_HDIV = 11'b001_0000_0000,
    S_IDIV = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

endpackage

// File: rtl/hover_thrust_rls_estimator.sv
// hover_thrust_rls_estimator: scalar RLS estimate of throttle-to-acceleration gain
// depends on hte_pkg; one shift-add multiplier and one restoring divider, both bit serial
//
// Usage:
//   Input words (command, throttle, acceleration) arrive on in_valid_i/in_ready_o, one
//   result word (hover throttle, gain, sample_used, guard_reset) leaves on
//   out_valid_o/out_ready_i. The user must write the registers over the APB port
//   only while idle; the block has no check for it. One word is worked on at a
//   time; in_ready_o is high while the sequencer is idle. A sample inside the
//   throttle window runs at most three 16-step multiplies, a 42-step division for
//   K, a 21-step multiply for the correction, a 32-step covariance division, a
//   16-step hover division and the S_HSET and S_DONE states; a restart runs at most
//   a 24-step division plus the hover division, and a sample outside the window only
//   the hover division; a saturated hover throttle skips its 16-step division. Each
//   step is a pass of the shared multiplier or divider, and the sequencer returns to
//   idle before the next accept, so a new word is taken only once the last is done.
//   The result sits in an output register, so the next word is taken while a
//   finished result still waits; a stalled receiver holds the sequencer in its last
//   state only once a second result is ready.
//   Reset loads the register defaults, gain 1285760 (Q8.16) and covariance 1.0,
//   and empties the output register.
module hover_thrust_rls_estimator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hte_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hte_pkg::out_t    out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration
  logic [15:0] lam_q, iht_q, tmin_q, tmax_q;
  logic [14:0] grav_q;
  logic        wr_en;

  // control
  hte_pkg::state_e state_q, state_d;
  logic [hte_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic [hte_pkg::GainW-1:0] gain_q, gain_d;
  logic [hte_pkg::CovW-1:0]  cov_q, cov_d;

  // datapath
  logic [15:0]               t_q, t_d;
  logic [15:0]               a_q, a_d;
  logic [47:0]               tp_q, tp_d;
  logic [hte_pkg::DivW-1:0]  d_q, d_d;
  logic [20:0]               res_q, res_d;
  logic [hte_pkg::MulW-1:0]  mc_q, mc_d, acc_q, acc_d, acc_nx;
  logic [hte_pkg::MprW-1:0]  mp_q, mp_d;
  logic [hte_pkg::DivW-1:0]  rem_q, rem_d, dvs_q, dvs_d, rem_nx;
  logic [hte_pkg::QuoW-1:0]  num_q, num_d, quo_q, quo_d, quo_nx;
  logic                      used_q, used_d, guard_q, guard_d;
  logic [15:0]               hov_q, hov_d;
  hte_pkg::out_t             out_q, out_d;

  logic [hte_pkg::DivW:0]    r2, sub;
  logic                      ge, last;
  logic [40:0]               pred_sum;
  logic [20:0]               res_c, resmag_c, resmag_q;
  logic [63:0]               rnd_sum;
  logic [47:0]               g48;
  logic [hte_pkg::CovW-1:0]  pq;
  logic                      in_fire;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q  <= hte_pkg::LAMBDA_RESET;
      grav_q <= hte_pkg::GRAV_RESET;
      iht_q  <= hte_pkg::IHT_RESET;
      tmin_q <= hte_pkg::TMIN_RESET;
      tmax_q <= hte_pkg::TMAX_RESET;
    end else if (wr_en) begin
      case (paddr[4:2])
        hte_pkg::REG_LAMBDA: lam_q  <= pwdata[15:0];
        hte_pkg::REG_GRAV:   grav_q <= pwdata[14:0];
        hte_pkg::REG_IHT:    iht_q  <= pwdata[15:0];
        hte_pkg::REG_TMIN:   tmin_q <= pwdata[15:0];
        hte_pkg::REG_TMAX:   tmax_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      hte_pkg::REG_LAMBDA: prdata = {16'b0, lam_q};
      hte_pkg::REG_GRAV:   prdata = {17'b0, grav_q};
      hte_pkg::REG_IHT:    prdata = {16'b0, iht_q};
      hte_pkg::REG_TMIN:   prdata = {16'b0, tmin_q};
      hte_pkg::REG_TMAX:   prdata = {16'b0, tmax_q};
      default:             prdata = 32'b0;
    endcase
  end

  // ---------------- serial units ----------------
  assign acc_nx = acc_q + (mp_q[0] ? mc_q : '0);

  assign r2     = {rem_q, num_q[hte_pkg::QuoW-1]};
  assign sub    = r2 - {1'b0, dvs_q};
  assign ge     = r2 >= {1'b0, dvs_q};
  assign rem_nx = ge ? sub[hte_pkg::DivW-1:0] : r2[hte_pkg::DivW-1:0];
  assign quo_nx = {quo_q[hte_pkg::QuoW-2:0], ge};
  assign last   = cnt_q == hte_pkg::CntW'(1);

  // prediction Q10.10 and residual Q11.10 (signed)
  assign pred_sum = acc_nx[40:0] + 41'h10_0000;
  assign res_c    = {{5{a_q[15]}}, a_q} - {1'b0, pred_sum[40:21]} + {6'b0, grav_q};
  assign resmag_c = res_c[20] ? (21'd0 - res_c) : res_c;
  assign resmag_q = res_q[20] ? (21'd0 - res_q) : res_q;

  // correction K*res rounded half away from zero
  assign rnd_sum = acc_nx + 64'h2_0000;
  assign g48     = res_q[20] ? ({24'b0, gain_q} - {2'b0, rnd_sum[63:18]})
                             : ({24'b0, gain_q} + {2'b0, rnd_sum[63:18]});
  assign pq      = quo_nx[hte_pkg::CovW-1:0];

  assign in_ready_o = state_q == hte_pkg::S_IDLE;
  assign in_fire    = in_valid_i & in_ready_o;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    gain_d      = gain_q;
    cov_d       = cov_q;
    t_d         = t_q;
    a_d         = a_q;
    tp_d        = tp_q;
    d_d         = d_q;
    res_d       = res_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    num_d       = num_q;
    quo_d       = quo_q;
    used_d      = used_q;
    guard_d     = guard_q;
    hov_d       = hov_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // one step of the multiplier or divider in their states
    if (state_q inside {hte_pkg::S_TP, hte_pkg::S_TPT, hte_pkg::S_PRED, hte_pkg::S_KRES}) begin
      acc_d = acc_nx;
      mc_d  = {mc_q[hte_pkg::MulW-2:0], 1'b0};
      mp_d  = {1'b0, mp_q[hte_pkg::MprW-1:1]};
      cnt_d = cnt_q - hte_pkg::CntW'(1);
    end
    if (state_q inside {hte_pkg::S_KDIV, hte_pkg::S_PDIV, hte_pkg::S_HDIV, hte_pkg::S_IDIV}) begin
      rem_d = rem_nx;
      quo_d = quo_nx;
      num_d = {num_q[hte_pkg::QuoW-2:0], 1'b0};
      cnt_d = cnt_q - hte_pkg::CntW'(1);
    end

    case (state_q)
      hte_pkg::S_IDLE: begin
        if (in_fire) begin
          t_d     = in_data_i.throttle_cmd;
          a_d     = in_data_i.vertical_accel;
          used_d  = 1'b0;
          guard_d = 1'b0;
          if (in_data_i.command == hte_pkg::CMD_RESTART) begin
            cov_d = hte_pkg::P_ONE;
            if ({4'b0, grav_q[14:3]} >= iht_q) begin
              gain_d  = hte_pkg::GAIN_MAX;
              state_d = hte_pkg::S_HSET;
            end else begin
              rem_d   = {38'b0, grav_q[14:3]};
              num_d   = {grav_q[2:0], 39'b0};
              dvs_d   = {34'b0, iht_q};
              quo_d   = '0;
              cnt_d   = hte_pkg::CntW'(24);
              state_d = hte_pkg::S_IDIV;
            end
          end else if (in_data_i.throttle_cmd >= tmin_q &&
                       in_data_i.throttle_cmd <= tmax_q) begin
            used_d  = 1'b1;
            mc_d    = {32'b0, cov_q};
            mp_d    = {5'b0, in_data_i.throttle_cmd};
            acc_d   = '0;
            cnt_d   = hte_pkg::CntW'(16);
            state_d = hte_pkg::S_TP;
          end else begin
            state_d = hte_pkg::S_HSET;
          end
        end
      end
      hte_pkg::S_TP: begin
        if (last) begin
          tp_d    = acc_nx[47:0];
          mc_d    = {16'b0, acc_nx[47:0]};
          mp_d    = {5'b0, t_q};
          acc_d   = '0;
          cnt_d   = hte_pkg::CntW'(16);
          state_d = hte_pkg::S_TPT;
        end
      end
      hte_pkg::S_TPT: begin
        if (last) begin
          // denominator lambda + t*t*P, Q.27
          d_d     = {22'b0, lam_q, 12'b0} + {1'b0, acc_nx[63:15]};
          mc_d    = {40'b0, gain_q};
          mp_d    = {5'b0, t_q};
          acc_d   = '0;
          cnt_d   = hte_pkg::CntW'(16);
          state_d = hte_pkg::S_PRED;
        end
      end
      hte_pkg::S_PRED: begin
        if (last) begin
          res_d = res_c;
          if (d_q == '0) begin
            // zero denominator leaves K at zero
            mc_d    = '0;
            mp_d    = resmag_c;
            acc_d   = '0;
            cnt_d   = hte_pkg::CntW'(21);
            state_d = hte_pkg::S_KRES;
          end else begin
            rem_d   = {20'b0, tp_q[47:18]};
            num_d   = {tp_q[17:0], 24'b0};
            dvs_d   = d_q;
            quo_d   = '0;
            cnt_d   = hte_pkg::CntW'(42);
            state_d = hte_pkg::S_KDIV;
          end
        end
      end
      hte_pkg::S_KDIV: begin
        if (last) begin
          mc_d    = {22'b0, quo_nx};
          mp_d    = resmag_q;
          acc_d   = '0;
          cnt_d   = hte_pkg::CntW'(21);
          state_d = hte_pkg::S_KRES;
        end
      end
      hte_pkg::S_KRES: begin
        if (last) begin
          if (g48[47] || g48 < hte_pkg::GAIN_MIN) begin
            gain_d  = {2'b0, grav_q, 7'b0};
            guard_d = 1'b1;
          end else if (g48 > {24'b0, hte_pkg::GAIN_MAX}) begin
            gain_d = hte_pkg::GAIN_MAX;
          end else begin
            gain_d = g48[hte_pkg::GainW-1:0];
          end
          // quotient P*2^27/D of 2^32 or more certainly trips the guard
          if ({23'b0, cov_q[31:5]} >= d_q) begin
            cov_d   = hte_pkg::P_ONE;
            guard_d = 1'b1;
            state_d = hte_pkg::S_HSET;
          end else begin
            rem_d   = {23'b0, cov_q[31:5]};
            num_d   = {cov_q[4:0], 37'b0};
            dvs_d   = d_q;
            quo_d   = '0;
            cnt_d   = hte_pkg::CntW'(32);
            state_d = hte_pkg::S_PDIV;
          end
        end
      end
      hte_pkg::S_PDIV: begin
        if (last) begin
          if (pq > hte_pkg::P_LIMIT) begin
            cov_d   = hte_pkg::P_ONE;
            guard_d = 1'b1;
          end else begin
            cov_d = pq;
          end
          state_d = hte_pkg::S_HSET;
        end
      end
      hte_pkg::S_HSET: begin
        // hover throttle saturates when the quotient needs more than 16 bits
        if ({4'b0, grav_q, 5'b0} >= gain_q) begin
          hov_d   = 16'hFFFF;
          state_d = hte_pkg::S_DONE;
        end else begin
          rem_d   = {30'b0, grav_q, 5'b0};
          num_d   = '0;
          dvs_d   = {26'b0, gain_q};
          quo_d   = '0;
          cnt_d   = hte_pkg::CntW'(16);
          state_d = hte_pkg::S_HDIV;
        end
      end
      hte_pkg::S_HDIV: begin
        if (last) begin
          hov_d   = quo_nx[15:0];
          state_d = hte_pkg::S_DONE;
        end
      end
      hte_pkg::S_IDIV: begin
        if (last) begin
          gain_d  = quo_nx[hte_pkg::GainW-1:0];
          state_d = hte_pkg::S_HSET;
        end
      end
      hte_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.hover_throttle = hov_q;
          out_d.gain_estimate  = gain_q;
          out_d.sample_used    = used_q;
          out_d.guard_reset    = guard_q;
          out_valid_d          = 1'b1;
          state_d              = hte_pkg::S_IDLE;
        end
      end
      default: state_d = hte_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hte_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= hte_pkg::GAIN_RESET;
      cov_q       <= hte_pkg::P_ONE;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      gain_q      <= gain_d;
      cov_q       <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    a_q     <= a_d;
    tp_q    <= tp_d;
    d_q     <= d_d;
    res_q   <= res_d;
    mc_q    <= mc_d;
    mp_q    <= mp_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    used_q  <= used_d;
    guard_q <= guard_d;
    hov_q   <= hov_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cov_q <= hte_pkg::P_LIMIT) else $error("covariance above guard limit");

  a_guard_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.guard_reset || out_data_o.sample_used))
    else $error("guard flagged on a word that did not update");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after accept");
`endif

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for hover_thrust_rls_estimator
// depends on hte_pkg and the rtl top; bit-exact gain/covariance predictor inside
module testbench;

  class rls_scoreboard;
    logic [15:0] lambda_r, grav_r, iht_r, tmin_r, tmax_r;
    logic [23:0] gain_q;
    logic [31:0] cov_q;
    hte_pkg::out_t pending_words[$];
    int errors;

    function new();
      lambda_r = hte_pkg::LAMBDA_RESET; grav_r = {1'b0, hte_pkg::GRAV_RESET};
      iht_r = hte_pkg::IHT_RESET;
      tmin_r = hte_pkg::TMIN_RESET; tmax_r = hte_pkg::TMAX_RESET;
      gain_q = seed_gain(); cov_q = hte_pkg::P_ONE; errors = 0;
    endfunction

    function logic [23:0] seed_gain();
      logic [63:0] q;
      if (iht_r == 16'd0) return hte_pkg::GAIN_MAX;
      q = ({49'd0, grav_r[14:0]} << 21) / {48'd0, iht_r};
      return (q > {40'd0, hte_pkg::GAIN_MAX}) ? hte_pkg::GAIN_MAX : q[23:0];
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        hte_pkg::REG_LAMBDA: lambda_r = v;
        hte_pkg::REG_GRAV:   grav_r = {1'b0, v[14:0]};
        hte_pkg::REG_IHT:    iht_r = v;
        hte_pkg::REG_TMIN:   tmin_r = v;
        default:             tmax_r = v;
      endcase
    endfunction

    // floor(n*2^s/d) with saturation, as the serial divider does it
    function logic [63:0] shifted_quot(logic [63:0] n, int s, logic [63:0] d);
      logic [63:0] q, r;
      q = n / d; r = n % d;
      for (int i = 0; i < s; i++) begin
        if (q[63:62] != 2'b00) return '1;
        q = q << 1; r = r << 1;
        if (r >= d) begin
          r = r - d; q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void note_input(hte_pkg::in_t w);
      logic [63:0] tp, d, k, pn, m, hv, t;
      longint signed a, pred, res, g, prod;
      hte_pkg::out_t o;
      o.sample_used = 1'b0; o.guard_reset = 1'b0;
      t = {48'd0, w.throttle_cmd};
      if (w.command == hte_pkg::CMD_RESTART) begin
        gain_q = seed_gain(); cov_q = hte_pkg::P_ONE;
      end else if (w.throttle_cmd >= tmin_r && w.throttle_cmd <= tmax_r) begin
        o.sample_used = 1'b1;
        tp = t * {32'd0, cov_q};
        d = ({48'd0, lambda_r} << 12) + ((tp * t) >> 15);
        k = '0;
        if (d != 64'd0) begin
          k = shifted_quot(tp, 24, d);
          pn = shifted_quot({32'd0, cov_q}, 27, d);
        end else pn = '1;
        a = w.vertical_accel;
        pred = longint'(({40'd0, gain_q} * t + 64'd1048576) >> 21);
        res = a - pred + longint'(grav_r);
        prod = longint'(k) * res;
        m = (prod < 0) ? -prod : prod;
        m = (m + 64'd131072) >> 18;
        g = longint'(gain_q) + ((prod < 0) ? -longint'(m) : longint'(m));
        if (pn > {32'd0, hte_pkg::P_LIMIT}) begin
          pn = {32'd0, hte_pkg::P_ONE}; o.guard_reset = 1'b1;
        end
        cov_q = pn[31:0];
        if (g < 66) begin
          g = longint'(grav_r) << 7; o.guard_reset = 1'b1;
        end else if (g > 64'hFFFFFF) g = 64'hFFFFFF;
        gain_q = g[23:0];
      end
      if (gain_q == 24'd0) hv = 64'hFFFF;
      else begin
        hv = ({49'd0, grav_r[14:0]} << 21) / {40'd0, gain_q};
        if (hv > 64'hFFFF) hv = 64'hFFFF;
      end
      o.hover_throttle = hv[15:0];
      o.gain_estimate = gain_q;
      pending_words.push_back(o);
    endfunction

    function void check_result(hte_pkg::out_t got);
      hte_pkg::out_t e;
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", got); errors++; return;
      end
      e = pending_words.pop_front();
      if (got.hover_throttle !== e.hover_throttle) begin
        $error("hover_throttle exp %0d got %0d", e.hover_throttle, got.hover_throttle);
        errors++;
      end
      if (got.gain_estimate !== e.gain_estimate) begin
        $error("gain_estimate exp %0d got %0d", e.gain_estimate, got.gain_estimate);
        errors++;
      end
      if (got.sample_used !== e.sample_used) begin
        $error("sample_used exp %0d got %0d", e.sample_used, got.sample_used); errors++;
      end
      if (got.guard_reset !== e.guard_reset) begin
        $error("guard_reset exp %0d got %0d", e.guard_reset, got.guard_reset); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  hte_pkg::in_t in_data_i = '0;
  hte_pkg::out_t out_data_o;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  rls_scoreboard sb;
  int stall_phase = 0;

  always #6 clk_i = ~clk_i;

  hover_thrust_rls_estimator dut (.*);

  // receiver stalls in a repeating pattern with random stretches
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 700 < 200) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic apb_write(logic [2:0] idx, logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_word(logic cmd, logic [15:0] t, logic [15:0] a);
    in_valid_i <= 1; in_data_i <= '{command: cmd, throttle_cmd: t, vertical_accel: a};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(in_data_i);
  endtask

  task automatic idle_gap();
    in_valid_i <= 0;
    repeat ($urandom_range(1, 30)) @(posedge clk_i);
  endtask

  // mostly in-window samples near the hover point, some outliers and restarts
  task automatic random_word();
    int r;
    logic [15:0] t, a;
    r = $urandom_range(0, 99);
    if (r < 5) send_word(hte_pkg::CMD_RESTART, 16'($urandom), 16'($urandom));
    else begin
      if (r < 15) t = 16'($urandom_range(0, 32768));
      else if (r < 20) t = 16'($urandom);
      else t = 16'($urandom_range(sb.tmin_r, sb.tmax_r > sb.tmin_r ? sb.tmax_r : sb.tmin_r));
      a = (r % 4 == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 2000)) - 1000);
      send_word(hte_pkg::CMD_SAMPLE, t, a);
    end
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) random_word();
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    in_valid_i <= 0;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: window edges, extremes, restart, zero throttle restart, zero lambda
    send_word(hte_pkg::CMD_SAMPLE, 16'd6554, 16'h7FFF);
    send_word(hte_pkg::CMD_SAMPLE, 16'd26214, 16'h8000);
    send_word(hte_pkg::CMD_SAMPLE, 16'd6553, 16'd0);
    send_word(hte_pkg::CMD_SAMPLE, 16'd26215, 16'd0);
    send_word(hte_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
    send_word(hte_pkg::CMD_RESTART, 16'hFFFF, 16'hFFFF);
    send_word(hte_pkg::CMD_SAMPLE, 16'd16384, 16'h8000);
    send_word(hte_pkg::CMD_SAMPLE, 16'd16384, 16'h8000);
    in_valid_i <= 0;
    drain();
    apb_write(hte_pkg::REG_LAMBDA, 16'd0);
    apb_write(hte_pkg::REG_TMIN, 16'd0);
    apb_write(hte_pkg::REG_TMAX, 16'd32768);
    apb_write(hte_pkg::REG_IHT, 16'd0);
    send_word(hte_pkg::CMD_SAMPLE, 16'd0, 16'd100);
    send_word(hte_pkg::CMD_SAMPLE, 16'd1, 16'd0);
    send_word(hte_pkg::CMD_SAMPLE, 16'd32768, 16'h7FFF);
    send_word(hte_pkg::CMD_RESTART, 16'd0, 16'd0);
    send_word(hte_pkg::CMD_SAMPLE, 16'd32768, 16'h8000);
    in_valid_i <= 0;
    drain();
    apb_write(hte_pkg::REG_GRAV, 16'd0);
    apb_write(hte_pkg::REG_IHT, 16'd32768);
    send_word(hte_pkg::CMD_RESTART, 16'd0, 16'd0);
    send_word(hte_pkg::CMD_SAMPLE, 16'd20000, 16'h8000);
    in_valid_i <= 0;
    drain();
    apb_write(hte_pkg::REG_TMIN, 16'd30000);
    apb_write(hte_pkg::REG_TMAX, 16'd1000);
    send_word(hte_pkg::CMD_SAMPLE, 16'd20000, 16'd5);
    in_valid_i <= 0;
    drain();
    // random phases across several settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          apb_write(hte_pkg::REG_LAMBDA, 16'd32113); apb_write(hte_pkg::REG_GRAV, 16'd10045);
          apb_write(hte_pkg::REG_IHT, 16'd16384); apb_write(hte_pkg::REG_TMIN, 16'd6554);
          apb_write(hte_pkg::REG_TMAX, 16'd26214);
        end
        1: begin
          apb_write(hte_pkg::REG_LAMBDA, 16'd29491); apb_write(hte_pkg::REG_GRAV, 16'd32767);
          apb_write(hte_pkg::REG_IHT, 16'd3277); apb_write(hte_pkg::REG_TMIN, 16'd0);
          apb_write(hte_pkg::REG_TMAX, 16'd32768);
        end
        2: begin
          apb_write(hte_pkg::REG_LAMBDA, 16'd32768); apb_write(hte_pkg::REG_GRAV, 16'd1);
          apb_write(hte_pkg::REG_IHT, 16'd32768);
        end
        default: begin
          apb_write(hte_pkg::REG_LAMBDA, 16'($urandom));
          apb_write(hte_pkg::REG_GRAV, 16'($urandom));
          apb_write(hte_pkg::REG_IHT, 16'($urandom));
          apb_write(hte_pkg::REG_TMIN, 16'($urandom_range(0, 16000)));
          apb_write(hte_pkg::REG_TMAX, 16'($urandom_range(16000, 65535)));
        end
      endcase
      send_word(hte_pkg::CMD_RESTART, 16'd0, 16'd0);
      random_phase(95);
      drain();  // sender holds off until every result is back
      random_phase(95);
      drain();
    end
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("** hover_thrust_rls_estimator: PASSED **");
    else
      $display("** hover_thrust_rls_estimator: FAILED **");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("** hover_thrust_rls_estimator: FAILED **");
    $finish;
  end
endmodule
